// ===== sv/kmcd_pkg.sv =====
package kmcd_pkg;

    // Configuration register file
    localparam int CFG_W = 4;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;
    localparam logic [CFG_W-1:0] ROWS_RESET = 4'd8;
    localparam logic [CFG_W-1:0] COLS_RESET = 4'd8;

    // Matrix geometry defaults and fixed field widths
    localparam int DEF_MAX_ROWS = 8;
    localparam int DEF_MAX_COLS = 8;
    localparam int NUM_ROW_PORTS = 8;
    localparam int RAW_W = 8;
    localparam logic [RAW_W-1:0] GROUNDED_ROW = 8'hFF;
    localparam int ROW_CODE_W = 3;
    localparam int COL_IW = 4;
    localparam int CODE_W = ROW_CODE_W + COL_IW;

    // Key results per word run, the closing sync not counted
    localparam int RES_CNT_W = 5;
    localparam logic [RES_CNT_W-1:0] MAX_KEY_RESULTS = 5'd31;

    typedef struct packed {
        logic capture;
        logic emit_key;
        logic skip_key;
        logic row_done;
        logic emit_sync;
    } t_ctrl_cmd;

    typedef struct packed {
        logic scan_good;
        logic row_end;
        logic has_bit;
        logic cnt_full;
        logic out_free;
    } t_dp_status;

endpackage

// ===== sv/kmcd_ctrl.sv =====
module kmcd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  kmcd_pkg::t_dp_status  i_status,
    output kmcd_pkg::t_ctrl_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_SYNC  = 2'd3;

    logic [1:0] r_fsm;
    logic [1:0] n_fsm;

    assign o_in_ready = (r_fsm == S_IDLE);

    always_comb begin
        n_fsm = r_fsm;
        o_cmd = '0;
        case (r_fsm)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_fsm = S_CHECK;
                end
            end
            S_CHECK: begin
                // failed read or ghosting: drop the word, no results
                n_fsm = i_status.scan_good ? S_WALK : S_IDLE;
            end
            S_WALK: begin
                if (i_status.row_end) begin
                    n_fsm = S_SYNC;
                end else if (i_status.has_bit) begin
                    if (i_status.cnt_full) begin
                        o_cmd.skip_key = 1'b1;
                    end else if (i_status.out_free) begin
                        o_cmd.emit_key = 1'b1;
                    end
                end else begin
                    o_cmd.row_done = 1'b1;
                end
            end
            S_SYNC: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sync = 1'b1;
                    n_fsm = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= S_IDLE;
        end else begin
            r_fsm <= n_fsm;
        end
    end

endmodule

// ===== sv/kmcd_dp.sv =====
module kmcd_dp #(
    parameter int MAX_ROWS = kmcd_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = kmcd_pkg::DEF_MAX_COLS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [kmcd_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [kmcd_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic                                   i_kind,
    input  logic                                   i_matrix_ok,
    input  logic [kmcd_pkg::NUM_ROW_PORTS-1:0][kmcd_pkg::RAW_W-1:0] i_rows,
    input  kmcd_pkg::t_ctrl_cmd                    i_cmd,
    output kmcd_pkg::t_dp_status                   o_status,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_is_sync,
    output logic [kmcd_pkg::CODE_W-1:0]            o_scan_code,
    output logic                                   o_pressed,
    output logic                                   o_last_of_run
);

    localparam int SW = MAX_COLS + 1;
    localparam int CW = kmcd_pkg::CFG_W;
    localparam int CIW = kmcd_pkg::COL_IW;
    localparam int ROW_IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    typedef logic [SW-1:0] t_row;
    typedef t_row t_row_arr [MAX_ROWS];

    logic [CW-1:0] r_rows_cfg;
    logic [CW-1:0] r_cols_cfg;
    t_row_arr      r_state;
    t_row_arr      r_next;
    t_row_arr      n_next;
    logic          r_ok;
    logic [CW-1:0] r_row;
    logic [kmcd_pkg::RES_CNT_W-1:0] r_cnt;

    logic          r_out_valid;
    logic          r_out_sync;
    logic [kmcd_pkg::CODE_W-1:0] r_out_code;
    logic          r_out_pressed;

    logic [CW-1:0]     w_rows;
    logic [CW-1:0]     w_cols;
    t_row              col_mask;
    t_row              low_mask;
    t_row              gnd_bit;
    logic [ROW_IW-1:0] row_idx;
    t_row              pend;
    t_row              low_bit;
    logic [CIW-1:0]    bit_col;
    logic              out_free;

    function automatic t_row translate(input logic [kmcd_pkg::RAW_W-1:0] raw,
                                       input t_row lmask, input t_row gnd);
        t_row res;
        if (raw == kmcd_pkg::GROUNDED_ROW) begin
            res = gnd;
        end else begin
            res = SW'(raw) & lmask;
        end
        return res;
    endfunction

    // a row with several keys that shares a column with any earlier row
    function automatic logic ghosted(input t_row_arr rows);
        t_row seen;
        t_row c;
        logic g;
        seen = '0;
        g = 1'b0;
        for (int r = 0; r < MAX_ROWS; r++) begin
            c = rows[r];
            if (((c & seen) != '0) && ((c & (c - 1'b1)) != '0)) begin
                g = 1'b1;
            end
            seen = seen | c;
        end
        return g;
    endfunction

    assign w_rows = (r_rows_cfg > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : r_rows_cfg;
    assign w_cols = (r_cols_cfg > CW'(MAX_COLS)) ? CW'(MAX_COLS) : r_cols_cfg;

    always_comb begin
        for (int c = 0; c < SW; c++) begin
            col_mask[c] = (CW'(c) <= w_cols);
            low_mask[c] = (CW'(c) < w_cols);
            gnd_bit[c]  = (CW'(c) == w_cols);
        end
    end

    always_comb begin
        for (int r = 0; r < MAX_ROWS; r++) begin
            if (i_kind && (CW'(r) < w_rows)) begin
                n_next[r] = translate(i_rows[r], low_mask, gnd_bit);
            end else begin
                n_next[r] = '0;
            end
        end
    end

    // walk: state bits are flipped as they are reported, so pend shrinks
    assign row_idx = r_row[ROW_IW-1:0];
    assign pend    = (r_next[row_idx] ^ r_state[row_idx]) & col_mask;
    assign low_bit = pend & ((~pend) + 1'b1);

    always_comb begin
        bit_col = '0;
        for (int c = SW - 1; c >= 0; c--) begin
            if (pend[c]) begin
                bit_col = CIW'(c);
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_status.scan_good = r_ok && !ghosted(r_next);
        o_status.row_end   = (r_row >= w_rows);
        o_status.has_bit   = (pend != '0);
        o_status.cnt_full  = (r_cnt == kmcd_pkg::MAX_KEY_RESULTS);
        o_status.out_free  = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= kmcd_pkg::ROWS_RESET;
            r_cols_cfg <= kmcd_pkg::COLS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kmcd_pkg::CFG_ROWS_IN_USE: r_rows_cfg <= i_cfg_data;
                kmcd_pkg::CFG_COLS_IN_USE: r_cols_cfg <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MAX_ROWS; r++) begin
                r_state[r] <= '0;
            end
        end else if (i_cmd.emit_key || i_cmd.skip_key) begin
            r_state[row_idx] <= r_state[row_idx] ^ low_bit;
        end else if (i_cmd.row_done) begin
            r_state[row_idx] <= r_next[row_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_next <= n_next;
            r_ok   <= !i_kind || i_matrix_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_cnt <= '0;
        end else if (i_cmd.capture) begin
            r_row <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.row_done) begin
                r_row <= r_row + 1'b1;
            end
            if (i_cmd.emit_key) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_key || i_cmd.emit_sync) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_key) begin
            r_out_sync    <= 1'b0;
            r_out_code    <= {r_row[kmcd_pkg::ROW_CODE_W-1:0], bit_col};
            r_out_pressed <= |(r_next[row_idx] & low_bit);
        end else if (i_cmd.emit_sync) begin
            r_out_sync    <= 1'b1;
            r_out_code    <= '0;
            r_out_pressed <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_is_sync     = r_out_sync;
    assign o_scan_code   = r_out_code;
    assign o_pressed     = r_out_pressed;
    assign o_last_of_run = r_out_sync;

endmodule

// ===== sv/keypad_matrix_change_detector_unit.sv =====
// Channel  | Handshake                 | Word
// ---------+---------------------------+-----------------------------------------
// input    | i_in_valid / o_in_ready   | i_kind, i_matrix_ok, i_row_0..i_row_7
// output   | o_out_valid / i_out_ready | o_is_sync, o_scan_code, o_pressed,
//          |                           | o_last_of_run
// config   | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One word at a time. After the accepting edge come the read/ghost check, then a step per
// row in use and a step per changed key (keys past the 31-result cap too), then a step to
// leave the walk and a step to load the sync result.
// A word that fails its read or shows ghosting is dropped after the check cycle.
// Synchronous active-low reset clears all stored key rows and sets 8 rows, 8 columns.
// A stalled output holds its word in the output register and pauses the walk.
module keypad_matrix_change_detector_unit #(
    parameter int MAX_ROWS = kmcd_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = kmcd_pkg::DEF_MAX_COLS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [kmcd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kmcd_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_kind,
    input  logic                           i_matrix_ok,
    input  logic [kmcd_pkg::RAW_W-1:0]     i_row_0,
    input  logic [kmcd_pkg::RAW_W-1:0]     i_row_1,
    input  logic [kmcd_pkg::RAW_W-1:0]     i_row_2,
    input  logic [kmcd_pkg::RAW_W-1:0]     i_row_3,
    input  logic [kmcd_pkg::RAW_W-1:0]     i_row_4,
    input  logic [kmcd_pkg::RAW_W-1:0]     i_row_5,
    input  logic [kmcd_pkg::RAW_W-1:0]     i_row_6,
    input  logic [kmcd_pkg::RAW_W-1:0]     i_row_7,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_is_sync,
    output logic [kmcd_pkg::CODE_W-1:0]    o_scan_code,
    output logic                           o_pressed,
    output logic                           o_last_of_run
);

    logic [kmcd_pkg::NUM_ROW_PORTS-1:0][kmcd_pkg::RAW_W-1:0] w_rows;
    kmcd_pkg::t_ctrl_cmd  w_cmd;
    kmcd_pkg::t_dp_status w_status;

    assign w_rows = {i_row_7, i_row_6, i_row_5, i_row_4,
                     i_row_3, i_row_2, i_row_1, i_row_0};

    kmcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    kmcd_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_kind),
        .i_matrix_ok   (i_matrix_ok),
        .i_rows        (w_rows),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_is_sync     (o_is_sync),
        .o_scan_code   (o_scan_code),
        .o_pressed     (o_pressed),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== sv/kmcd_checker.sv =====
module kmcd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_is_sync,
    input logic [kmcd_pkg::CODE_W-1:0] o_scan_code,
    input logic                        o_pressed,
    input logic                        o_last_of_run
);

    // only the sync word closes a run
    a_last_is_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_of_run == o_is_sync))
        else $error("last_of_run does not match is_sync");

    a_sync_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_sync) |-> (o_scan_code == '0 && !o_pressed))
        else $error("sync word carries key data");

    // one word in flight: ready drops right after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a word is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_scan_code) && $stable(o_is_sync)
             && $stable(o_pressed)))
        else $error("stalled output word changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind keypad_matrix_change_detector_unit kmcd_checker u_kmcd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_is_sync     (o_is_sync),
    .o_scan_code   (o_scan_code),
    .o_pressed     (o_pressed),
    .o_last_of_run (o_last_of_run)
);
